### rtl/core/memory_pattern_scanner_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the memory pattern scanner
// Concurrent checks on the rising clock, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef MEMORY_PATTERN_SCANNER_DEFINES_SVH
`define MEMORY_PATTERN_SCANNER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define MPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the following cycle.
`define MPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/mps_pkg.sv
// ----------------------------------------------------------------------------
// mps_pkg
// Shared widths, register indexes and types of the memory pattern scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package mps_pkg;

	// Field widths
	localparam int DATA_W      = 8;
	localparam int ADDR_W      = 48;
	localparam int NUM_W       = 32;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int RAW_LEN_W   = 5;
	localparam int PATTERN_W   = 2 * CFG_DATA_W;

	// Parameter defaults
	localparam int MAX_PATTERN_DEF  = 16;
	localparam int ADDRESS_BITS_DEF = 48;

	// Reset value of the pattern length register
	localparam int LEN_RESET = 4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd2;

	// Per-request control handed to the window
	typedef struct packed {
		logic advance;
		logic new_block;
	} mps_step_t;

endpackage

`default_nettype wire

### rtl/core/mps_window.sv
// ----------------------------------------------------------------------------
// mps_window
// Holds the recent bytes of the stream and the byte count of the current block,
// and compares the window ending at the current byte with the pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module mps_window #(
	parameter int MAX_PATTERN = mps_pkg::MAX_PATTERN_DEF,
	localparam int LEN_W = $clog2(MAX_PATTERN + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mps_pkg::mps_step_t            step,
	input  wire logic [mps_pkg::DATA_W-1:0]    data_byte,
	input  wire logic [mps_pkg::PATTERN_W-1:0] pattern,
	input  wire logic [LEN_W-1:0]              len,
	output logic                               hit
);
	import mps_pkg::*;

	localparam int WIN_D = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
	localparam int PIDX_W = 4;

	logic [DATA_W-1:0] recent_q [WIN_D];
	logic [DATA_W-1:0] win      [MAX_PATTERN];
	logic [LEN_W-1:0]  count_q;
	logic [LEN_W-1:0]  count_next;
	logic [MAX_PATTERN-1:0] byte_ok;

	// Count bytes of the block, restart on a block mark, saturate at the window size
	always_comb begin
		if (step.new_block) begin
			count_next = LEN_W'(1);
		end else if (count_q < LEN_W'(MAX_PATTERN)) begin
			count_next = count_q + LEN_W'(1);
		end else begin
			count_next = count_q;
		end
	end

	// Compare each window slot with its pattern byte, slot zero is the current byte
	always_comb begin
		logic [PIDX_W-1:0] pidx;
		pidx = '0;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			win[k] = (k == 0) ? data_byte : recent_q[(k == 0) ? 0 : k - 1];
			if (k < int'(len)) begin
				pidx = PIDX_W'(int'(len) - 1 - k);
				byte_ok[k] = (pattern[DATA_W * pidx +: DATA_W] == win[k]);
			end else begin
				byte_ok[k] = 1'b1;
			end
		end
		hit = (count_next >= len) && (&byte_ok);
	end

	// Shift the current byte into the window
	always_ff @(posedge clk) begin
		if (step.advance) begin
			recent_q[0] <= data_byte;
			for (int i = 1; i < WIN_D; i++) begin
				recent_q[i] <= recent_q[i - 1];
			end
		end
	end

	// Advance the block byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (step.advance) begin
			count_q <= count_next;
		end
	end

endmodule

`default_nettype wire

### rtl/core/memory_pattern_scanner.sv
// ----------------------------------------------------------------------------
// memory_pattern_scanner
// Sliding-window scan of a byte stream for a configured pattern.
// ----------------------------------------------------------------------------
// The scanner takes one byte request per clock while results are taken and
// reports each match of the configured 1 to MAX_PATTERN byte pattern with the
// start address of the window and a running match number that restarts at
// scan_start and saturates at all ones. A request sits in the input register,
// where the full window is compared in parallel against the pattern, and a
// match lands in the output register; one byte per cycle is sustained as long
// as results are taken. The rate is set by the combinational window compare
// between the input and output registers. Configuration is written while the
// scanner is idle, which the block itself does not enforce; a pattern length
// of zero acts as one and lengths above MAX_PATTERN act as MAX_PATTERN.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_pattern_scanner #(
	parameter int MAX_PATTERN  = mps_pkg::MAX_PATTERN_DEF,
	parameter int ADDRESS_BITS = mps_pkg::ADDRESS_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration
	input  wire logic                           cfg_wen,
	input  wire logic [mps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mps_pkg::CFG_DATA_W-1:0] cfg_data,
	// byte requests
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [mps_pkg::DATA_W-1:0]     data_byte,
	input  wire logic [mps_pkg::ADDR_W-1:0]     byte_address,
	input  wire logic                           block_start,
	input  wire logic                           scan_start,
	// match results
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [mps_pkg::ADDR_W-1:0]          match_address,
	output logic [mps_pkg::NUM_W-1:0]           match_number
);
	import mps_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int LEN_INIT = (LEN_RESET < MAX_PATTERN) ? LEN_RESET : MAX_PATTERN;
	localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDRESS_BITS >= ADDR_W) ?
		{ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);

	// configuration registers
	logic [LEN_W-1:0]      len_q;
	logic [CFG_DATA_W-1:0] pat_low_q;
	logic [CFG_DATA_W-1:0] pat_high_q;
	logic [LEN_W-1:0]      len_eff;
	logic [RAW_LEN_W-1:0]  len_raw;

	// input stage
	logic              valid_s1;
	logic [DATA_W-1:0] data_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              blk_s1;
	logic              scan_s1;

	// output stage
	logic              valid_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [NUM_W-1:0]  num_s2;

	logic [NUM_W-1:0]  matches_q;
	logic [NUM_W-1:0]  matches_base;
	logic [NUM_W-1:0]  matches_next;
	logic [ADDR_W-1:0] start_addr;
	logic              accept;
	logic              advance;
	logic              hit;
	mps_step_t         step;

	// Clamp the written length to one through MAX_PATTERN
	always_comb begin
		len_raw = cfg_data[RAW_LEN_W-1:0];
		if (len_raw == '0) begin
			len_eff = LEN_W'(1);
		end else if (int'(len_raw) > MAX_PATTERN) begin
			len_eff = LEN_W'(MAX_PATTERN);
		end else begin
			len_eff = LEN_W'(len_raw);
		end
	end

	// Decode register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= LEN_W'(LEN_INIT);
			pat_low_q  <= '0;
			pat_high_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_PATTERN_LENGTH: len_q      <= len_eff;
				CFG_PATTERN_LOW:    pat_low_q  <= cfg_data;
				CFG_PATTERN_HIGH:   pat_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: the input stage moves on when the output register is free or drains
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || !valid_s2 || out_ready;
	assign accept   = in_valid && in_ready;

	// Hold the request in the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= data_byte;
			addr_s1 <= byte_address;
			blk_s1  <= block_start;
			scan_s1 <= scan_start;
		end
	end

	// Window compare
	assign step.advance   = advance;
	assign step.new_block = blk_s1 || scan_s1;

	mps_window #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.data_byte(data_s1),
		.pattern  ({pat_high_q, pat_low_q}),
		.len      (len_q),
		.hit      (hit)
	);

	// Number the match within the scan, saturating at all ones
	always_comb begin
		matches_base = scan_s1 ? '0 : matches_q;
		if (hit && (matches_base != {NUM_W{1'b1}})) begin
			matches_next = matches_base + NUM_W'(1);
		end else begin
			matches_next = matches_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matches_q <= '0;
		end else if (advance) begin
			matches_q <= matches_next;
		end
	end

	// Back the address up to the first byte of the window
	assign start_addr = (addr_s1 - ADDR_W'(len_q) + ADDR_W'(1)) & ADDR_MASK;

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= hit;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit) begin
			addr_s2 <= start_addr;
			num_s2  <= matches_next;
		end
	end

	assign out_valid     = valid_s2;
	assign match_address = addr_s2;
	assign match_number  = num_s2;

endmodule

`default_nettype wire

### rtl/core/mps_checker.sv
// ----------------------------------------------------------------------------
// mps_checker
// Port-level checks of the memory pattern scanner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "memory_pattern_scanner_defines.svh"

module mps_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic [mps_pkg::ADDR_W-1:0] match_address,
	input wire logic [mps_pkg::NUM_W-1:0]  match_number
);

	// A stalled result holds its payload
	`MPS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(match_address) && $stable(match_number), "stalled result changed")

	// Match numbers count from one
	`MPS_ASSERT_SAME(a_num_nonzero, clk, arst_n, out_valid, match_number != '0, "match number is zero")

	// Requests are refused only behind a stalled result
	`MPS_ASSERT_SAME(a_ready_stall, clk, arst_n, !in_ready, out_valid && !out_ready, "request refused without output stall")

	// A waiting request is taken while the output drains
	`MPS_ASSERT_SAME(a_ready_recover, clk, arst_n, in_valid && out_ready, in_ready, "request refused while output drains")

endmodule

bind memory_pattern_scanner mps_checker u_mps_checker (.*);

`default_nettype wire
